// File: hdl/sha_pkg.sv
package sha_pkg;

	localparam int unsigned BlockWords = 16;
	localparam int unsigned HashWords  = 8;
	localparam int unsigned Rounds     = 64;

	localparam logic [7:0] PadMark = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LDH,
		ST_LDW,
		ST_RND,
		ST_UPD,
		ST_ORD,
		ST_OWAIT
	} sha_state_t;

	typedef logic [31:0] word_t;

	localparam word_t RoundK [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t InitH [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t ror(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage

// File: hdl/sha_byte_if.sv
interface sha_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

// File: hdl/sha_digest_if.sv
interface sha_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hdl/sha_ram.sv
module sha_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/sha256_message_digest_core.sv
// SHA-256 over a byte stream. One byte is taken per cycle while gathering; the 64th byte
// of a block starts the compression (load the chaining words from their RAM, load the
// block RAM into the schedule, 64 rounds at one per cycle, add back and write the
// chaining RAM), during which no byte is taken. End of message runs one padding byte
// per cycle through the same path (up to 64, plus a second compression when the length
// does not fit), then the eight digest words come out of the chaining RAM one at a time,
// H0 first, after which the core starts afresh.
module sha256_message_digest_core
	import sha_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sha_byte_if.sink      byte_in,
	sha_digest_if.source  digest_out
);

	sha_state_t  state_q, state_d, ret_q;
	logic [6:0]  cnt_q;
	logic [5:0]  fill_q;
	logic [23:0] acc_q;
	logic [63:0] bits_q;
	logic        mark_q, lenblk_q, hinit_q;
	logic [2:0]  k_q;
	word_t       v_q [HashWords];
	word_t       w_q [BlockWords];

	logic        accept, byte_go, full;
	logic [7:0]  byte_val, pad_byte;

	logic        buf_we;
	logic [3:0]  buf_raddr;
	word_t       buf_rdata;
	logic        ch_we;
	logic [2:0]  ch_waddr, ch_raddr, ld_idx;
	word_t       ch_wdata, ch_rdata, h_old;
	word_t       t1, t2, w_new;

	assign accept = byte_in.valid && byte_in.ready;
	assign byte_in.ready = (state_q == ST_IDLE);

	// length goes out most significant byte first
	assign pad_byte = !mark_q ? PadMark :
		(lenblk_q && fill_q >= 6'd56) ? bits_q[{~fill_q[2:0], 3'b000} +: 8] : 8'h00;

	always_comb begin
		byte_go  = 1'b0;
		byte_val = byte_in.data_byte;
		if (state_q == ST_IDLE) begin
			byte_go = accept && byte_in.byte_valid;
		end else if (state_q == ST_PAD) begin
			byte_go  = 1'b1;
			byte_val = pad_byte;
		end
	end

	assign full   = byte_go && (fill_q == 6'd63);
	assign buf_we = byte_go && (fill_q[1:0] == 2'd3);
	assign buf_raddr = cnt_q[3:0];

	sha_ram #(.WIDTH(32), .DEPTH(BlockWords)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (fill_q[5:2]),
		.wdata ({acc_q, byte_val}),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	assign ld_idx   = cnt_q[2:0] - 3'd1;
	assign h_old    = hinit_q ? InitH[ld_idx] : ch_rdata;
	assign ch_we    = (state_q == ST_UPD) && (cnt_q != 7'd0);
	assign ch_waddr = ld_idx;
	assign ch_wdata = h_old + v_q[0];
	assign ch_raddr = (state_q == ST_ORD || state_q == ST_OWAIT) ? k_q : cnt_q[2:0];

	sha_ram #(.WIDTH(32), .DEPTH(HashWords)) u_chain (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (ch_wdata),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ RoundK[cnt_q[5:0]] + w_q[0];
	assign t2 = big_sig0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign w_new = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];

	assign digest_out.valid       = (state_q == ST_OWAIT);
	assign digest_out.digest_word = ch_rdata;
	assign digest_out.word_index  = k_q;
	assign digest_out.last_word   = (k_q == 3'd7);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (full) begin
					state_d = ST_LDH;
				end else if (accept && byte_in.end_of_message) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (full) begin
					state_d = ST_LDH;
				end
			end
			ST_LDH: begin
				if (cnt_q == 7'd8) begin
					state_d = ST_LDW;
				end
			end
			ST_LDW: begin
				if (cnt_q == 7'd16) begin
					state_d = ST_RND;
				end
			end
			ST_RND: begin
				if (cnt_q == 7'd63) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (cnt_q == 7'd8) begin
					state_d = ret_q;
				end
			end
			ST_ORD: state_d = ST_OWAIT;
			ST_OWAIT: begin
				if (digest_out.ready) begin
					state_d = (k_q == 3'd7) ? ST_IDLE : ST_ORD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q    <= ST_IDLE;
			cnt_q    <= '0;
			fill_q   <= '0;
			bits_q   <= '0;
			mark_q   <= 1'b0;
			lenblk_q <= 1'b0;
			hinit_q  <= 1'b1;
			k_q      <= '0;
		end else begin
			cnt_q <= (state_d != state_q) ? 7'd0 : cnt_q + 7'd1;
			if (byte_go) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && byte_in.byte_valid) begin
						bits_q <= bits_q + 64'd8;
					end
					if (accept && byte_in.end_of_message) begin
						mark_q   <= 1'b0;
						lenblk_q <= 1'b0;
					end
					if (full) begin
						ret_q <= byte_in.end_of_message ? ST_PAD : ST_IDLE;
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					// length fits behind the mark only when it lands before byte 56
					if (!mark_q && fill_q < 6'd56) begin
						lenblk_q <= 1'b1;
					end
					if (full) begin
						ret_q    <= lenblk_q ? ST_ORD : ST_PAD;
						lenblk_q <= 1'b1;
					end
				end
				ST_UPD: begin
					if (cnt_q == 7'd8) begin
						hinit_q <= 1'b0;
					end
				end
				ST_OWAIT: begin
					if (digest_out.ready) begin
						k_q <= k_q + 3'd1;
						if (k_q == 3'd7) begin
							bits_q  <= '0;
							hinit_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (byte_go) begin
			acc_q <= {acc_q[15:0], byte_val};
		end
		case (state_q)
			ST_LDH: begin
				if (cnt_q != 7'd0) begin
					for (int i = 0; i < HashWords - 1; i++) begin
						v_q[i] <= v_q[i+1];
					end
					v_q[HashWords-1] <= h_old;
				end
			end
			ST_LDW: begin
				if (cnt_q != 7'd0) begin
					for (int i = 0; i < BlockWords - 1; i++) begin
						w_q[i] <= w_q[i+1];
					end
					w_q[BlockWords-1] <= buf_rdata;
				end
			end
			ST_RND: begin
				v_q[0] <= t1 + t2;
				v_q[1] <= v_q[0];
				v_q[2] <= v_q[1];
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3] + t1;
				v_q[5] <= v_q[4];
				v_q[6] <= v_q[5];
				v_q[7] <= v_q[6];
				for (int i = 0; i < BlockWords - 1; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[BlockWords-1] <= w_new;
			end
			ST_UPD: begin
				if (cnt_q != 7'd0) begin
					for (int i = 0; i < HashWords - 1; i++) begin
						v_q[i] <= v_q[i+1];
					end
					v_q[HashWords-1] <= v_q[0];
				end
			end
			default: ;
		endcase
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sha_pkg::*;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   mismatch_seen = 1'b0;
	bit   no_gaps = 1'b0;

	sha_byte_if   byte_in ();
	sha_digest_if digest_out ();

	sha256_message_digest_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in.sink),
		.digest_out (digest_out.source)
	);

	always #4 clk = ~clk;

	// predictor state
	word_t        hash_state [HashWords];
	logic [7:0]   msg_block [64];
	int unsigned  fill_count;
	logic [63:0]  bit_count;
	digest_item_t expected_digest [$];

	function automatic word_t rotr(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress();
		word_t w [64];
		word_t v [8];
		word_t s0, s1, t1, t2, ch, mj;
		for (int t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int t = 0; t < 64; t++) begin
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
				+ RoundK[t] + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + mj;
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = InitH[i];
		fill_count = 0;
		bit_count = '0;
	endfunction

	function automatic void predict_digest(logic [7:0] b, logic bv, logic eom);
		int unsigned pos;
		digest_item_t d;
		if (bv) begin
			msg_block[fill_count] = b;
			fill_count++;
			bit_count += 64'd8;
			if (fill_count == 64) begin
				compress();
				fill_count = 0;
			end
		end
		if (!eom)
			return;
		pos = fill_count;
		msg_block[pos++] = PadMark;
		if (pos > 56) begin
			while (pos < 64)
				msg_block[pos++] = 8'h00;
			compress();
			pos = 0;
		end
		while (pos < 56)
			msg_block[pos++] = 8'h00;
		for (int i = 0; i < 8; i++)
			msg_block[56+i] = bit_count[63-8*i -: 8];
		compress();
		for (int k = 0; k < 8; k++) begin
			d.digest_word = hash_state[k];
			d.word_index = k[2:0];
			d.last_word = (k == 7);
			expected_digest.push_back(d);
		end
		restart_hash();
	endfunction

	function automatic bit take_gap();
		return !no_gaps && ($urandom_range(99) < 32);
	endfunction

	// valid is left high on return; the next call or wait_drained decides what follows
	task automatic send_byte(logic [7:0] b, logic bv, logic eom);
		while (take_gap()) begin
			byte_in.valid <= 1'b0;
			@(negedge clk);
		end
		byte_in.valid <= 1'b1;
		byte_in.data_byte <= b;
		byte_in.byte_valid <= bv;
		byte_in.end_of_message <= eom;
		@(posedge clk);
		while (!byte_in.ready)
			@(posedge clk);
		predict_digest(b, bv, eom);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		byte_in.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_digest.size() != 0);
	endtask

	task automatic send_message(int len, bit junk);
		for (int i = 0; i < len; i++) begin
			if (junk && $urandom_range(5) == 0)
				send_byte(8'($urandom), 1'b0, 1'b0);
			send_byte(8'($urandom), 1'b1, (i == len - 1));
		end
	endtask

	// result sink
	always @(negedge clk)
		digest_out.ready <= !take_gap();

	always @(posedge clk) begin
		digest_item_t exp_d;
		if (arst_n && digest_out.valid && digest_out.ready) begin
			if (expected_digest.size() == 0) begin
				$error("unexpected digest word %h", digest_out.digest_word);
				mismatch_seen = 1'b1;
			end else begin
				exp_d = expected_digest.pop_front();
				if (digest_out.digest_word !== exp_d.digest_word) begin
					$error("digest_word: expected %h, got %h",
						exp_d.digest_word, digest_out.digest_word);
					mismatch_seen = 1'b1;
				end
				if (digest_out.word_index !== exp_d.word_index) begin
					$error("word_index: expected %0d, got %0d",
						exp_d.word_index, digest_out.word_index);
					mismatch_seen = 1'b1;
				end
				if (digest_out.last_word !== exp_d.last_word) begin
					$error("last_word: expected %b, got %b",
						exp_d.last_word, digest_out.last_word);
					mismatch_seen = 1'b1;
				end
			end
		end
	end

	task automatic test_empty_messages();
		send_byte(8'hff, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_single_bytes();
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'hff, 1'b1, 1'b1);
		// "abc"
		send_byte(8'h61, 1'b1, 1'b0);
		send_byte(8'h62, 1'b1, 1'b0);
		send_byte(8'h55, 1'b0, 1'b0);
		send_byte(8'h63, 1'b1, 1'b1);
	endtask

	task automatic test_padding_edges();
		// 55 fits the length, 56 needs an extra block, 64 fills a block exactly
		send_message(55, 1'b0);
		wait_drained();
		send_message(56, 1'b0);
		no_gaps = 1'b1;
		send_message(64, 1'b0);
		no_gaps = 1'b0;
	endtask

	task automatic test_random_messages();
		int len;
		for (int m = 0; m < 7; m++) begin
			len = $urandom_range(1, 6);
			no_gaps = (m >= 2 && m < 5);
			send_message(len, 1'b1);
			if ($urandom_range(3) == 0)
				send_byte(8'($urandom), 1'b0, 1'b1);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		byte_in.valid = 1'b0;
		byte_in.data_byte = '0;
		byte_in.byte_valid = 1'b0;
		byte_in.end_of_message = 1'b0;
		digest_out.ready = 1'b0;
		restart_hash();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_messages();
		test_single_bytes();
		test_padding_edges();
		test_random_messages();
		wait_drained();
		repeat (200) @(negedge clk);
		if (!mismatch_seen)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
